FILE: rtl/ows_pkg.sv
// Shared types and constants for the 1-Wire over SPI slot codec.
// No dependencies; imported by every module of the block.
`default_nettype none

package ows_pkg;

    // operation codes carried on the input channel
    localparam logic [2:0] OP_RESET   = 3'd0;
    localparam logic [2:0] OP_WRITE   = 3'd1;
    localparam logic [2:0] OP_READ    = 3'd2;
    localparam logic [2:0] OP_DELAY   = 3'd3;
    localparam logic [2:0] OP_RX_SLOT = 3'd4;

    // result kinds
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // SPI byte patterns for the slots
    localparam logic [7:0] SLOT_ZERO = 8'h03;
    localparam logic [7:0] SLOT_ONE  = 8'h7F;
    localparam logic [7:0] SLOT_MASK = 8'h70;
    localparam logic [7:0] IDLE_BYTE = 8'hFF;
    localparam logic [7:0] LOW_BYTE  = 8'h00;

    // beat index within one item's run
    localparam int unsigned IDX_W = 4;
    localparam logic [IDX_W-1:0] RESET_LOW_CNT = 4'd7;
    localparam logic [IDX_W-1:0] RESET_LAST    = 4'd10;
    localparam logic [IDX_W-1:0] BYTE_LAST     = 4'd7;

    // one beat of the current item, from the generator to the top level
    typedef struct packed {
        logic       emit;   // beat produces a result
        logic       done;   // final beat of the item
        logic       kind;
        logic [7:0] value;
    } beat_t;

    // control strobes to the receive assembler
    typedef struct packed {
        logic step;   // a received slot is taken in
        logic clear;  // bus reset clears the partial byte
    } rx_ctl_t;

    // assembler status back to the generator
    typedef struct packed {
        logic       done;  // this slot completes a byte
        logic [7:0] data;  // assembled byte including this slot
    } rx_stat_t;

endpackage

`default_nettype wire

FILE: rtl/ows_rx_asm.sv
// Receive assembler: collects read-slot bits LSB first into a byte.
// Depends on ows_pkg.
`default_nettype none

module ows_rx_asm
    import ows_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire rx_ctl_t    ctl,
    input  wire logic [7:0] slot_byte,
    output rx_stat_t        stat
);

    logic [2:0] bit_count_reg, bit_count_next;
    logic [7:0] rx_shift_reg, rx_shift_next;
    logic [7:0] merged;
    logic       slot_bit;

    always_comb begin
        slot_bit = ((slot_byte & SLOT_MASK) == SLOT_MASK);
        merged   = rx_shift_reg | (8'(slot_bit) << bit_count_reg);
        stat.done = (bit_count_reg == 3'd7);
        stat.data = merged;

        bit_count_next = bit_count_reg;
        rx_shift_next  = rx_shift_reg;
        if (ctl.clear) begin
            bit_count_next = '0;
            rx_shift_next  = '0;
        end else if (ctl.step) begin
            if (stat.done) begin
                bit_count_next = '0;
                rx_shift_next  = '0;
            end else begin
                bit_count_next = bit_count_reg + 3'd1;
                rx_shift_next  = merged;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_count_reg <= '0;
            rx_shift_reg  <= '0;
        end else begin
            bit_count_reg <= bit_count_next;
            rx_shift_reg  <= rx_shift_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ows_slot_gen.sv
// Slot generator: picks the SPI byte for one beat of the current item.
// Depends on ows_pkg.
`default_nettype none

module ows_slot_gen
    import ows_pkg::*;
(
    input  wire logic [2:0]       operation,
    input  wire logic [7:0]       data,
    input  wire logic [IDX_W-1:0] idx,
    input  wire logic             invert_tx,
    input  wire rx_stat_t         rx,
    output beat_t                 beat
);

    logic [7:0] tx_byte;

    always_comb begin
        tx_byte    = IDLE_BYTE;
        beat.emit  = 1'b1;
        beat.done  = 1'b1;
        beat.kind  = KIND_TX;
        unique case (operation)
            OP_RESET: begin
                tx_byte   = (idx < RESET_LOW_CNT) ? LOW_BYTE : IDLE_BYTE;
                beat.done = (idx == RESET_LAST);
            end
            OP_WRITE: begin
                tx_byte   = data[idx[2:0]] ? SLOT_ONE : SLOT_ZERO;
                beat.done = (idx == BYTE_LAST);
            end
            OP_READ: begin
                tx_byte   = SLOT_ONE;
                beat.done = (idx == BYTE_LAST);
            end
            OP_DELAY: begin
                tx_byte = IDLE_BYTE;
            end
            OP_RX_SLOT: begin
                beat.emit = rx.done;
                beat.kind = KIND_DATA;
            end
            default: begin
                beat.emit = 1'b0;
            end
        endcase
        // received bytes are never inverted
        beat.value = (beat.kind == KIND_DATA) ? rx.data : (tx_byte ^ {8{invert_tx}});
    end

endmodule

`default_nettype wire

FILE: rtl/onewire_spi_slot_codec_core.sv
// Top level of the 1-Wire over SPI slot codec: input register, beat
// sequencing and result register. Depends on ows_pkg, ows_slot_gen, ows_rx_asm.
`default_nettype none

// Usage:
//   s_ channel: one item per operation; s_tuser = operation, s_tdata = data.
//   m_ channel: results; m_tdata = value, m_tuser = kind, m_tlast marks the
//   final result of an item.
//   cfg_we/cfg_wdata write invert_tx; write only while the block is idle.
// Path: an accepted item is held in the input register, and each of its
// results is then registered in the result register.
// Throughput: one result per cycle while the result register can take it. The
// input register holds an item for one beat per SPI byte or slot: 11 beats for
// a bus reset, 8 for a write or read byte, 1 for a delay, a received slot or an
// unused code. The beat counter in the input stage sets that figure; a new
// item is taken in the same cycle as its predecessor's final beat fires.
// Reset: aresetn (synchronous, active low) empties both registers, clears
// the receive bit count and the partial byte, and sets invert_tx to 0.
// Stall: while m_tready is low and the result register is full, it holds and
// the input stage waits on any beat that has a result; s_tready is low while
// the input register is occupied and its final beat is not taken.
module onewire_spi_slot_codec_core
    import ows_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,   // invert_tx
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,     // [7:0] data
    input  wire logic [2:0] s_tuser,     // [2:0] operation
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,     // [7:0] value
    output logic            m_tuser,     // [0] kind
    output logic            m_tlast
);

    logic             invert_reg;
    logic             in_valid_reg;
    logic [2:0]       op_reg;
    logic [7:0]       data_reg;
    logic [IDX_W-1:0] idx_reg;

    logic             m_valid_reg;
    logic [7:0]       m_value_reg;
    logic             m_kind_reg;
    logic             m_last_reg;

    beat_t    beat;
    rx_ctl_t  rx_ctl;
    rx_stat_t rx_stat;
    logic     out_ready;
    logic     fire;
    logic     take;
    logic     accept;

    ows_slot_gen u_gen (
        .operation (op_reg),
        .data      (data_reg),
        .idx       (idx_reg),
        .invert_tx (invert_reg),
        .rx        (rx_stat),
        .beat      (beat)
    );

    ows_rx_asm u_rx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (rx_ctl),
        .slot_byte (data_reg),
        .stat      (rx_stat)
    );

    always_comb begin
        out_ready    = !m_valid_reg || m_tready;
        fire         = in_valid_reg && (!beat.emit || out_ready);
        take         = fire && beat.done;
        s_tready     = !in_valid_reg || take;
        accept       = s_tvalid && s_tready;
        rx_ctl.step  = fire && (op_reg == OP_RX_SLOT);
        rx_ctl.clear = fire && (op_reg == OP_RESET);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_reg   <= 1'b0;
            in_valid_reg <= 1'b0;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                invert_reg <= cfg_wdata;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (fire) begin
                idx_reg <= beat.done ? '0 : idx_reg + 1'b1;
            end
            if (out_ready) begin
                m_valid_reg <= fire && beat.emit;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_tuser;
            data_reg <= s_tdata;
        end
        if (fire && beat.emit) begin
            m_value_reg <= beat.value;
            m_kind_reg  <= beat.kind;
            m_last_reg  <= beat.done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= RESET_LAST)
        else $error("beat index out of range");

    a_idx_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg != '0) |-> in_valid_reg)
        else $error("beat index running without an item");

    a_data_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_DATA)) |-> m_tlast)
        else $error("decoded byte without tlast");

    a_mid_run_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !take) |=> (in_valid_reg && $stable(op_reg)))
        else $error("item left the input stage before its final beat");
`endif

endmodule

`default_nettype wire

FILE: dv/onewire_spi_slot_codec_core_tb.sv
// Self-checking testbench for onewire_spi_slot_codec_core: directed and random
// 1-Wire operations are streamed in and each SPI or decoded byte is checked.
// Depends on ows_pkg and the RTL of the codec only.
`default_nettype none

module onewire_spi_slot_codec_core_tb;
    import ows_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_PCT         = 11;
    localparam int unsigned SILENCE_LIMIT    = 1000;
    localparam int unsigned DRAIN_CYCLES     = 16;
    localparam int unsigned REPORT_MAX       = 10;
    localparam int unsigned RESET_LOW_BEATS  = 7;
    localparam int unsigned RESET_HIGH_BEATS = 4;
    localparam logic [2:0]  LAST_SLOT_BIT    = 3'd7;
    localparam logic [2:0]  OP_FIRST_UNUSED  = 3'd5;
    localparam logic [2:0]  OP_LAST_CODE     = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
    } wire_op_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
    } codec_beat_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [2:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    wire_op_t    pending_ops[$];
    codec_beat_t expected_beats[$];

    // shadow of the block's state
    logic        tx_invert;
    logic [2:0]  rx_bits_seen;
    logic [7:0]  rx_assembly;

    logic        s_taken;
    logic        steady;
    int unsigned fail_count;
    int unsigned quiet_cycles;

    onewire_spi_slot_codec_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic codec_beat_t tx_beat(input logic [7:0] pattern);
        codec_beat_t b;
        b.kind  = KIND_TX;
        b.value = tx_invert ? ~pattern : pattern;
        b.last  = 1'b0;
        return b;
    endfunction

    // SPI bytes and decoded bytes caused by one 1-Wire operation
    function automatic void predict_slots(input wire_op_t it);
        codec_beat_t run[$];
        codec_beat_t b;
        case (it.op)
            OP_RESET: begin
                rx_bits_seen = '0;
                rx_assembly  = '0;
                for (int i = 0; i < RESET_LOW_BEATS; i++) run.push_back(tx_beat(LOW_BYTE));
                for (int i = 0; i < RESET_HIGH_BEATS; i++) run.push_back(tx_beat(IDLE_BYTE));
            end
            OP_WRITE: begin
                for (int i = 0; i < 8; i++)
                    run.push_back(tx_beat(it.data[i] ? SLOT_ONE : SLOT_ZERO));
            end
            OP_READ: begin
                for (int i = 0; i < 8; i++) run.push_back(tx_beat(SLOT_ONE));
            end
            OP_DELAY: begin
                run.push_back(tx_beat(IDLE_BYTE));
            end
            OP_RX_SLOT: begin
                if ((it.data & SLOT_MASK) == SLOT_MASK) rx_assembly[rx_bits_seen] = 1'b1;
                if (rx_bits_seen == LAST_SLOT_BIT) begin
                    b.kind  = KIND_DATA;
                    b.value = rx_assembly;
                    b.last  = 1'b0;
                    run.push_back(b);
                    rx_bits_seen = '0;
                    rx_assembly  = '0;
                end else begin
                    rx_bits_seen = rx_bits_seen + 3'd1;
                end
            end
            default: ;
        endcase
        if (run.size() != 0) run[run.size() - 1].last = 1'b1;
        foreach (run[i]) expected_beats.push_back(run[i]);
    endfunction

    task automatic note_failure(input string what, input logic [7:0] want,
                                input logic [7:0] got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s: expected %02h, got %02h", $realtime, what, want, got);
    endtask

    // driver: next item goes out once the current one is taken
    always @(negedge aclk) begin
        wire_op_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (pending_ops.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                it = pending_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it.op;
                s_tdata  <= it.data;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // monitor: predict on input handshakes, check on output handshakes
    always @(posedge aclk) begin
        wire_op_t    it;
        codec_beat_t got;
        codec_beat_t want;
        if (!aresetn) begin
            s_taken = 1'b0;
        end else begin
            s_taken = s_tvalid && s_tready;
            if (s_taken) begin
                it.op   = s_tuser;
                it.data = s_tdata;
                predict_slots(it);
            end
            if (m_tvalid && m_tready) begin
                got.kind  = m_tuser;
                got.value = m_tdata;
                got.last  = m_tlast;
                if (expected_beats.size() == 0) begin
                    note_failure("result with nothing expected", 8'h00, got.value);
                end else begin
                    want = expected_beats.pop_front();
                    if (got.kind != want.kind)
                        note_failure("kind", 8'(want.kind), 8'(got.kind));
                    if (got.value != want.value)
                        note_failure("value", want.value, got.value);
                    if (got.last != want.last)
                        note_failure("last", 8'(want.last), 8'(got.last));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles == SILENCE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic queue_op(input logic [2:0] op, input logic [7:0] data);
        wire_op_t it;
        it.op   = op;
        it.data = data;
        pending_ops.push_back(it);
    endtask

    // received SPI byte; half the time the slot mask bits are forced high
    function automatic logic [7:0] rx_sample();
        logic [7:0] d;
        d = 8'($urandom_range(255));
        if ($urandom_range(1) == 1) d = d | SLOT_MASK;
        return d;
    endfunction

    task automatic queue_random(input int unsigned count);
        int unsigned made;
        int unsigned pick;
        int unsigned slots;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(99);
            if (pick < 32) begin
                for (int i = 0; i < 8; i++) queue_op(OP_RX_SLOT, rx_sample());
                made += 8;
            end else if (pick < 47) begin
                queue_op(OP_WRITE, 8'($urandom_range(255)));
                made++;
            end else if (pick < 56) begin
                queue_op(OP_READ, 8'($urandom_range(255)));
                made++;
            end else if (pick < 65) begin
                queue_op(OP_DELAY, 8'($urandom_range(255)));
                made++;
            end else if (pick < 71) begin
                queue_op(OP_RESET, 8'($urandom_range(255)));
                made++;
            end else if (pick < 79) begin
                // byte cut short by a bus reset
                slots = $urandom_range(7, 1);
                for (int i = 0; i < slots; i++) queue_op(OP_RX_SLOT, rx_sample());
                queue_op(OP_RESET, 8'($urandom_range(255)));
                made += slots + 1;
            end else if (pick < 85) begin
                queue_op(3'($urandom_range(OP_LAST_CODE, OP_FIRST_UNUSED)),
                         8'($urandom_range(255)));
                made++;
            end else begin
                queue_op(OP_RX_SLOT, rx_sample());
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_ops.size() != 0 || s_tvalid || expected_beats.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_invert(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        tx_invert = v;
    endtask

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_RESET;
        m_tready     = 1'b0;
        s_taken      = 1'b0;
        steady       = 1'b0;
        fail_count   = 0;
        quiet_cycles = 0;
        tx_invert    = 1'b0;
        rx_bits_seen = '0;
        rx_assembly  = '0;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: every operation, data extremes, ignored codes, reset mid-byte
        queue_op(OP_RESET, 8'hFF);
        queue_op(OP_WRITE, 8'h00);
        queue_op(OP_WRITE, 8'hFF);
        queue_op(OP_WRITE, 8'hA5);
        queue_op(OP_READ, 8'hC3);
        queue_op(OP_DELAY, 8'h5A);
        queue_op(OP_FIRST_UNUSED, 8'h00);
        queue_op(3'd6, 8'hFF);
        queue_op(OP_LAST_CODE, 8'h81);
        queue_op(OP_RX_SLOT, 8'h70);
        queue_op(OP_RX_SLOT, 8'h7F);
        queue_op(OP_RX_SLOT, 8'h00);
        queue_op(OP_RX_SLOT, 8'hFF);
        queue_op(OP_RX_SLOT, 8'h6F);
        queue_op(OP_RX_SLOT, 8'hF0);
        queue_op(OP_RX_SLOT, 8'h30);
        queue_op(OP_RX_SLOT, 8'h8F);
        queue_op(OP_RX_SLOT, 8'h70);
        queue_op(OP_RX_SLOT, 8'hF7);
        queue_op(OP_RESET, 8'h00);
        queue_op(OP_DELAY, 8'h00);
        wait_drained();

        write_invert(1'b1);
        queue_random(95);
        wait_drained();

        // long stretch without idling on either side
        write_invert(1'b0);
        steady = 1'b1;
        queue_random(95);
        wait_drained();
        steady = 1'b0;

        write_invert(1'b1);
        queue_random(100);
        wait_drained();

        write_invert(1'b0);
        queue_random(95);
        wait_drained();

        if (fail_count == 0 && expected_beats.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
